// ===== hw/rtl/ttl_pkg.sv =====
// Shared types and constants for the template tag lexer.
package ttl_pkg;

   localparam int FIELD_W = 20;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = 2;

   typedef enum logic [4:0] {
      KIND_TEXT       = 5'd0,
      KIND_BEGIN      = 5'd1,
      KIND_BEGIN_TRIM = 5'd2,
      KIND_END        = 5'd3,
      KIND_END_TRIM   = 5'd4,
      KIND_PIPE       = 5'd5,
      KIND_COMMA      = 5'd6,
      KIND_LPAREN     = 5'd7,
      KIND_RPAREN     = 5'd8,
      KIND_HASH       = 5'd9,
      KIND_DOT        = 5'd10,
      KIND_QUESTION   = 5'd11,
      KIND_SLASH      = 5'd12,
      KIND_IDENT      = 5'd13,
      KIND_IF         = 5'd14,
      KIND_RANGE      = 5'd15,
      KIND_END_KW     = 5'd16,
      KIND_INCLUDE    = 5'd17,
      KIND_EOF        = 5'd18
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_DASH       = 3'd1,
      ERR_DASH_BRACE = 3'd2,
      ERR_BRACE      = 3'd3,
      ERR_STRING     = 3'd4,
      ERR_CHAR       = 3'd5
   } err_type;

   typedef enum logic [3:0] {
      M_TEXT, M_TBRACE, M_TBEGIN, M_IDLE, M_DASH, M_DASHB, M_RBRACE, M_SLASH,
      M_COMM, M_COMMSTAR, M_STR, M_NUM, M_NUMDOT, M_FRAC, M_IDENT
   } mode_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [4:0]         token_kind;
      logic [2:0]         error_code;
      logic [FIELD_W-1:0] start_index;
      logic [FIELD_W-1:0] lexeme_length;
      logic [FIELD_W-1:0] line_number;
      logic [FIELD_W-1:0] column;
      logic               value_trimmed;
      logic               last_of_run;
   } rsp_type;

   // all results caused by one transaction
   typedef struct packed {
      logic [1:0]    count;
      rsp_type [2:0] item;
   } bundle_type;

   // keyword spelling, one byte per position
   function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      case (k)
         2'd0: case (pos)
            3'd0: c = "i"; 3'd1: c = "f"; default: c = 8'h00;
         endcase
         2'd1: case (pos)
            3'd0: c = "r"; 3'd1: c = "a"; 3'd2: c = "n"; 3'd3: c = "g"; 3'd4: c = "e";
            default: c = 8'h00;
         endcase
         2'd2: case (pos)
            3'd0: c = "e"; 3'd1: c = "n"; 3'd2: c = "d"; default: c = 8'h00;
         endcase
         default: case (pos)
            3'd0: c = "i"; 3'd1: c = "n"; 3'd2: c = "c"; 3'd3: c = "l"; 3'd4: c = "u";
            3'd5: c = "d"; 3'd6: c = "e"; default: c = 8'h00;
         endcase
      endcase
      return c;
   endfunction

   function automatic logic [3:0] kw_len(input logic [1:0] k);
      logic [3:0] n;
      case (k)
         2'd0: n = 4'd2;
         2'd1: n = 4'd5;
         2'd2: n = 4'd3;
         default: n = 4'd7;
      endcase
      return n;
   endfunction

endpackage

// ===== hw/rtl/ttl_front.sv =====
// Lexer front end: tracks position and mode, forms the results of each transaction.
module ttl_front #(
   parameter int POSITION_BITS = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  ttl_pkg::req_type    req_item,
   output logic                bundle_push,
   output ttl_pkg::bundle_type bundle
);
   import ttl_pkg::*;

   localparam int PB = POSITION_BITS;
   localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
   localparam logic [PB-1:0] POS_ONE = PB'(1);

   mode_type mode_ff, mode_in;
   logic [PB-1:0] idx_ff, idx_in, line_ff, line_in, col_ff, col_in;
   logic [PB-1:0] st_idx_ff, st_idx_in, st_line_ff, st_line_in, st_col_ff, st_col_in;
   logic [PB-1:0] br_idx_ff, br_idx_in, br_line_ff, br_line_in, br_col_ff, br_col_in;
   logic [3:0] kw_ff, kw_in, len_ff, len_in;

   logic [7:0] b;
   logic [PB-1:0] nx_idx, nx_line, nx_col;
   logic [1:0] n;
   logic do_idle;
   logic is_digit, is_alpha;
   kind_type ident_kind;
   bundle_type res;

   function automatic rsp_type mk(input kind_type kind, input err_type err,
                                  input logic [PB-1:0] sidx, input logic [PB-1:0] eidx,
                                  input logic [PB-1:0] ln, input logic [PB-1:0] cl,
                                  input logic trim);
      rsp_type r;
      logic [PB-1:0] d;
      d = eidx - sidx;
      r.token_kind = kind;
      r.error_code = err;
      r.start_index = FIELD_W'(sidx);
      r.lexeme_length = FIELD_W'(d);
      r.line_number = FIELD_W'(ln);
      r.column = FIELD_W'(cl);
      r.value_trimmed = trim;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic logic [3:0] kw_step(input logic [3:0] flags, input logic [3:0] ln,
                                          input logic [7:0] c);
      logic [3:0] f;
      f = flags;
      for (int k = 0; k < 4; k++) begin
         if (ln >= kw_len(2'(k)) || kw_char(2'(k), ln[2:0]) != c) begin
            f[k] = 1'b0;
         end
      end
      return f;
   endfunction

   assign b = req_item.byte_in;
   assign is_digit = (b >= "0") && (b <= "9");
   assign is_alpha = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");

   // saturating next position
   always_comb begin
      nx_idx = (idx_ff == POS_MAX) ? idx_ff : idx_ff + POS_ONE;
      if (b == 8'h0A) begin
         nx_col = '0;
         nx_line = (line_ff == POS_MAX) ? line_ff : line_ff + POS_ONE;
      end else begin
         nx_col = (col_ff == POS_MAX) ? col_ff : col_ff + POS_ONE;
         nx_line = line_ff;
      end
   end

   // keyword resolution of the pending identifier
   always_comb begin
      ident_kind = KIND_IDENT;
      for (int k = 0; k < 4; k++) begin
         if (kw_ff[k] && len_ff == kw_len(2'(k))) begin
            ident_kind = kind_type'(5'(int'(KIND_IF) + k));
         end
      end
   end

   // lex one transaction
   always_comb begin
      mode_in = mode_ff;
      idx_in = idx_ff; line_in = line_ff; col_in = col_ff;
      st_idx_in = st_idx_ff; st_line_in = st_line_ff; st_col_in = st_col_ff;
      br_idx_in = br_idx_ff; br_line_in = br_line_ff; br_col_in = br_col_ff;
      kw_in = kw_ff; len_in = len_ff;
      res = '0;
      n = 2'd0;
      do_idle = 1'b0;
      if (accept) begin
         if (req_item.end_of_source) begin
            // flush pending lexeme
            unique case (mode_ff)
               M_TEXT, M_TBRACE: begin
                  if (idx_ff > st_idx_ff) begin
                     res.item[n] = mk(KIND_TEXT, ERR_NONE, st_idx_ff, idx_ff, st_line_ff,
                                      st_col_ff, 1'b0);
                     n = n + 2'd1;
                  end
               end
               M_TBEGIN: begin
                  if (br_idx_ff > st_idx_ff) begin
                     res.item[n] = mk(KIND_TEXT, ERR_NONE, st_idx_ff, br_idx_ff, st_line_ff,
                                      st_col_ff, 1'b0);
                     n = n + 2'd1;
                  end
                  res.item[n] = mk(KIND_BEGIN, ERR_NONE, br_idx_ff, idx_ff, br_line_ff,
                                   br_col_ff, 1'b0);
                  n = n + 2'd1;
               end
               M_DASH, M_DASHB, M_RBRACE, M_STR: begin
                  res.item[n] = mk(KIND_TEXT,
                                   (mode_ff == M_DASH) ? ERR_DASH :
                                   (mode_ff == M_DASHB) ? ERR_DASH_BRACE :
                                   (mode_ff == M_RBRACE) ? ERR_BRACE : ERR_STRING,
                                   st_idx_ff, idx_ff, st_line_ff, st_col_ff, 1'b0);
                  n = n + 2'd1;
               end
               M_SLASH, M_NUM, M_FRAC, M_IDENT: begin
                  res.item[n] = mk((mode_ff == M_SLASH) ? KIND_SLASH :
                                   (mode_ff == M_IDENT) ? ident_kind : KIND_IDENT,
                                   ERR_NONE, st_idx_ff, idx_ff, st_line_ff, st_col_ff, 1'b0);
                  n = n + 2'd1;
               end
               M_NUMDOT: begin
                  res.item[n] = mk(KIND_IDENT, ERR_NONE, st_idx_ff, br_idx_ff, st_line_ff,
                                   st_col_ff, 1'b0);
                  n = n + 2'd1;
                  res.item[n] = mk(KIND_DOT, ERR_NONE, br_idx_ff, br_idx_ff + POS_ONE,
                                   br_line_ff, br_col_ff, 1'b0);
                  n = n + 2'd1;
               end
               default: ;
            endcase
            res.item[n] = mk(KIND_EOF, ERR_NONE, idx_ff, idx_ff, line_ff, col_ff, 1'b0);
            n = n + 2'd1;
            // return to reset state
            mode_in = M_TEXT;
            idx_in = '0; line_in = POS_ONE; col_in = '0;
            st_idx_in = '0; st_line_in = POS_ONE; st_col_in = '0;
            br_idx_in = '0; br_line_in = POS_ONE; br_col_in = '0;
            kw_in = 4'hF; len_in = '0;
         end else begin
            unique case (mode_ff)
               M_TEXT: begin
                  if (b == "{") begin
                     mode_in = M_TBRACE;
                     br_idx_in = idx_ff; br_line_in = line_ff; br_col_in = col_ff;
                  end
               end
               M_TBRACE: mode_in = (b == "{") ? M_TBEGIN : M_TEXT;
               M_TBEGIN: begin
                  if (br_idx_ff > st_idx_ff) begin
                     res.item[n] = mk(KIND_TEXT, ERR_NONE, st_idx_ff, br_idx_ff, st_line_ff,
                                      st_col_ff, 1'b0);
                     n = n + 2'd1;
                  end
                  if (b == "-") begin
                     res.item[n] = mk(KIND_BEGIN_TRIM, ERR_NONE, br_idx_ff, nx_idx,
                                      br_line_ff, br_col_ff, 1'b0);
                     n = n + 2'd1;
                     mode_in = M_IDLE;
                     st_idx_in = nx_idx; st_line_in = nx_line; st_col_in = nx_col;
                  end else begin
                     res.item[n] = mk(KIND_BEGIN, ERR_NONE, br_idx_ff, idx_ff, br_line_ff,
                                      br_col_ff, 1'b0);
                     n = n + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_IDLE: do_idle = 1'b1;
               M_DASH: begin
                  if (b == "}") begin
                     mode_in = M_DASHB;
                  end else begin
                     res.item[n] = mk(KIND_TEXT, ERR_DASH, st_idx_ff, idx_ff, st_line_ff,
                                      st_col_ff, 1'b0);
                     n = n + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_DASHB, M_RBRACE: begin
                  if (b == "}") begin
                     res.item[n] = mk((mode_ff == M_DASHB) ? KIND_END_TRIM : KIND_END,
                                      ERR_NONE, st_idx_ff, nx_idx, st_line_ff, st_col_ff,
                                      1'b0);
                     n = n + 2'd1;
                     mode_in = M_TEXT;
                     st_idx_in = nx_idx; st_line_in = nx_line; st_col_in = nx_col;
                  end else begin
                     res.item[n] = mk(KIND_TEXT,
                                      (mode_ff == M_DASHB) ? ERR_DASH_BRACE : ERR_BRACE,
                                      st_idx_ff, idx_ff, st_line_ff, st_col_ff, 1'b0);
                     n = n + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_SLASH: begin
                  if (b == "*") begin
                     mode_in = M_COMM;
                  end else begin
                     res.item[n] = mk(KIND_SLASH, ERR_NONE, st_idx_ff, idx_ff, st_line_ff,
                                      st_col_ff, 1'b0);
                     n = n + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_COMM: begin
                  if (b == "*") mode_in = M_COMMSTAR;
               end
               M_COMMSTAR: begin
                  if (b == "/") mode_in = M_IDLE;
                  else if (b != "*") mode_in = M_COMM;
               end
               M_STR: begin
                  if (b == 8'h22) begin
                     res.item[n] = mk(KIND_IDENT, ERR_NONE, st_idx_ff, nx_idx, st_line_ff,
                                      st_col_ff, 1'b1);
                     n = n + 2'd1;
                     mode_in = M_IDLE;
                  end
               end
               M_NUM, M_FRAC: begin
                  if (is_digit) begin
                     mode_in = mode_ff;
                  end else if (mode_ff == M_NUM && b == ".") begin
                     mode_in = M_NUMDOT;
                     br_idx_in = idx_ff; br_line_in = line_ff; br_col_in = col_ff;
                  end else begin
                     res.item[n] = mk(KIND_IDENT, ERR_NONE, st_idx_ff, idx_ff, st_line_ff,
                                      st_col_ff, 1'b0);
                     n = n + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_NUMDOT: begin
                  if (is_digit) begin
                     mode_in = M_FRAC;
                  end else begin
                     res.item[n] = mk(KIND_IDENT, ERR_NONE, st_idx_ff, br_idx_ff, st_line_ff,
                                      st_col_ff, 1'b0);
                     n = n + 2'd1;
                     res.item[n] = mk(KIND_DOT, ERR_NONE, br_idx_ff, br_idx_ff + POS_ONE,
                                      br_line_ff, br_col_ff, 1'b0);
                     n = n + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               M_IDENT: begin
                  if (is_alpha || is_digit) begin
                     kw_in = kw_step(kw_ff, len_ff, b);
                     len_in = (len_ff == 4'hF) ? len_ff : len_ff + 4'd1;
                  end else begin
                     res.item[n] = mk(ident_kind, ERR_NONE, st_idx_ff, idx_ff, st_line_ff,
                                      st_col_ff, 1'b0);
                     n = n + 2'd1;
                     do_idle = 1'b1;
                  end
               end
               default: mode_in = M_TEXT;
            endcase

            // lex the byte afresh inside a tag
            if (do_idle) begin
               st_idx_in = idx_ff; st_line_in = line_ff; st_col_in = col_ff;
               mode_in = M_IDLE;
               if (b == "|" || b == "," || b == "(" || b == ")" || b == "#" || b == "." ||
                   b == "?") begin
                  res.item[n] = mk((b == "|") ? KIND_PIPE : (b == ",") ? KIND_COMMA :
                                   (b == "(") ? KIND_LPAREN : (b == ")") ? KIND_RPAREN :
                                   (b == "#") ? KIND_HASH : (b == ".") ? KIND_DOT :
                                   KIND_QUESTION, ERR_NONE, idx_ff, idx_ff + POS_ONE,
                                   line_ff, col_ff, 1'b0);
                  n = n + 2'd1;
               end else if (b == "-") begin
                  mode_in = M_DASH;
               end else if (b == "}") begin
                  mode_in = M_RBRACE;
               end else if (b == "/") begin
                  mode_in = M_SLASH;
               end else if (b == 8'h22) begin
                  mode_in = M_STR;
               end else if (is_digit) begin
                  mode_in = M_NUM;
               end else if (is_alpha) begin
                  mode_in = M_IDENT;
                  kw_in = kw_step(4'hF, 4'd0, b);
                  len_in = 4'd1;
               end else if (b != " " && b != 8'h0D && b != 8'h0A && b != 8'h09) begin
                  res.item[n] = mk(KIND_TEXT, ERR_CHAR, idx_ff, idx_ff + POS_ONE,
                                   line_ff, col_ff, 1'b0);
                  n = n + 2'd1;
               end
            end
            idx_in = nx_idx; line_in = nx_line; col_in = nx_col;
         end
      end
      // mark the last result of the transaction
      for (int i = 0; i < 3; i++) begin
         res.item[i].last_of_run = (n == 2'(i + 1));
      end
      res.count = n;
   end

   assign bundle = res;
   assign bundle_push = accept && (n != 2'd0);

   // hold lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_TEXT;
         idx_ff <= '0; line_ff <= POS_ONE; col_ff <= '0;
         st_idx_ff <= '0; st_line_ff <= POS_ONE; st_col_ff <= '0;
         br_idx_ff <= '0; br_line_ff <= POS_ONE; br_col_ff <= '0;
         kw_ff <= 4'hF; len_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         idx_ff <= idx_in; line_ff <= line_in; col_ff <= col_in;
         st_idx_ff <= st_idx_in; st_line_ff <= st_line_in; st_col_ff <= st_col_in;
         br_idx_ff <= br_idx_in; br_line_ff <= br_line_in; br_col_ff <= br_col_in;
         kw_ff <= kw_in; len_ff <= len_in;
      end
   end

endmodule

// ===== hw/rtl/ttl_queue.sv =====
// Short queue of result bundles between the lexer and the result sequencer.
module ttl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ttl_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output ttl_pkg::bundle_type head
);
   import ttl_pkg::*;

   bundle_type slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_AW:0] cnt_ff, cnt_in;

   assign full = (cnt_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head = slot_ff[rd_ff];

   // advance pointers
   always_comb begin
      wr_in = push ? wr_ff + 1'b1 : wr_ff;
      rd_in = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // store bundle
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/ttl_back.sv =====
// Result sequencer: hands out each bundle's results one per cycle while taken.
module ttl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  ttl_pkg::bundle_type head,
   output logic                q_pop,
   output logic                out_valid,
   output ttl_pkg::rsp_type    out_item,
   input  logic                out_take
);
   import ttl_pkg::*;

   logic [1:0] sub_ff, sub_in;
   logic valid_ff, valid_in;
   rsp_type item_ff, item_in;
   logic load;

   assign load = !q_empty && (!valid_ff || out_take);
   assign q_pop = load && (sub_ff == head.count - 2'd1);

   // step through the bundle and refill the output register
   always_comb begin
      sub_in = sub_ff;
      valid_in = valid_ff && !out_take;
      item_in = item_ff;
      if (load) begin
         item_in = head.item[sub_ff];
         valid_in = 1'b1;
         sub_in = q_pop ? 2'd0 : sub_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item = item_ff;

endmodule

// ===== hw/rtl/template_tag_lexer.sv =====
// Top level of the template tag lexer.
// Takes one source byte per cycle while not full (push/full) and returns tokens
// and error items (empty/pop), with start index, length, line and column; an
// end-of-source transaction flushes, emits eof and restarts the counters. Each
// byte is lexed by the state machine; a byte can cause up to three results, which
// queue as one bundle in a four-entry queue and leave at one result per cycle
// while popped, through an output register, sustaining one byte per cycle unless
// results average more than one per byte. Positions saturate at 2^POSITION_BITS-1.
module template_tag_lexer #(
   parameter int POSITION_BITS = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ttl_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output ttl_pkg::rsp_type rsp_item
);
   import ttl_pkg::*;

   logic accept, b_push, q_full, q_empty, q_pop, out_valid;
   bundle_type b_data, q_head;

   assign full = q_full;
   assign accept = push && !q_full;

   ttl_front #(.POSITION_BITS(POSITION_BITS)) u_front (
      .clock(clock), .reset(reset), .accept(accept), .req_item(req_item),
      .bundle_push(b_push), .bundle(b_data)
   );

   ttl_queue u_queue (
      .clock(clock), .reset(reset), .push(b_push), .push_data(b_data), .full(q_full),
      .pop(q_pop), .empty(q_empty), .head(q_head)
   );

   ttl_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .head(q_head), .q_pop(q_pop),
      .out_valid(out_valid), .out_item(rsp_item), .out_take(pop)
   );

   assign empty = !out_valid;

endmodule
